### src/wsd_pkg.sv
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_KEY     = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [2:0] EXT16_BYTES    = 3'd2;
   localparam logic [2:0] EXT64_BYTES    = 3'd0;
   localparam logic [2:0] KEY_BYTES      = 3'd4;

   typedef struct packed {
      logic       step;
      logic [7:0] rx_byte;
   } step_type;

   typedef struct packed {
      logic        is_header;
      logic        final_fragment;
      logic [3:0]  frame_opcode;
      logic        is_control;
      logic        was_masked;
      logic [63:0] frame_length;
      logic [7:0]  payload_byte;
      logic        end_of_frame;
   } result_type;

endpackage

### src/wsd_in_reg.sv
module wsd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic              out_free,
   output wsd_pkg::step_type step
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       advance;
   logic       load;

   assign advance   = valid_ff && out_free;
   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign step.step    = advance;
   assign step.rx_byte = byte_ff;

endmodule

### src/wsd_parser.sv
module wsd_parser (
   input  logic                clock,
   input  logic                reset,
   input  wsd_pkg::step_type   step,
   output logic                res_valid,
   output wsd_pkg::result_type res
);

   wsd_pkg::phase_type phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] length_ff, length_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] left_ff, left_in;
   logic [1:0]  key_index_ff, key_index_in;

   logic [7:0]  b;
   logic [63:0] left_dec;
   logic [7:0]  key_byte;
   logic        length_done;
   logic        header_done;
   logic        payload_out;
   logic        last;

   assign b        = step.rx_byte;
   assign left_dec = left_ff - 64'd1;
   assign last     = (left_dec == 64'd0);

   always_comb begin
      unique case (key_index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      mask_in      = mask_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      left_in      = left_ff;
      key_index_in = key_index_ff;
      length_done  = 1'b0;
      header_done  = 1'b0;
      payload_out  = 1'b0;

      unique case (phase_ff)
         wsd_pkg::PH_HDR1: begin
            mask_in  = b[7];
            count_in = 3'd0;
            if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
               length_in = 64'd0;
               phase_in  = wsd_pkg::PH_EXT16;
            end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
               length_in = 64'd0;
               phase_in  = wsd_pkg::PH_EXT64;
            end else begin
               length_in   = {57'd0, b[6:0]};
               length_done = 1'b1;
            end
         end
         wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
            length_in = {length_ff[55:0], b};
            count_in  = count_ff + 3'd1;
            if ((phase_ff == wsd_pkg::PH_EXT16 && count_in == wsd_pkg::EXT16_BYTES) ||
                (phase_ff == wsd_pkg::PH_EXT64 && count_in == wsd_pkg::EXT64_BYTES)) begin
               length_done = 1'b1;
            end
         end
         wsd_pkg::PH_KEY: begin
            key_in   = {key_ff[23:0], b};
            count_in = count_ff + 3'd1;
            if (count_in == wsd_pkg::KEY_BYTES) begin
               header_done = 1'b1;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            left_in      = left_dec;
            key_index_in = key_index_ff + 2'd1;
            payload_out  = 1'b1;
            if (last) begin
               phase_in = wsd_pkg::PH_HDR0;
            end
         end
         default: begin
            fin_in       = b[7];
            opcode_in    = b[3:0];
            mask_in      = 1'b0;
            key_in       = 32'd0;
            length_in    = 64'd0;
            count_in     = 3'd0;
            left_in      = 64'd0;
            key_index_in = 2'd0;
            phase_in     = wsd_pkg::PH_HDR1;
         end
      endcase

      if (length_done) begin
         count_in = 3'd0;
         if (mask_in) begin
            phase_in = wsd_pkg::PH_KEY;
         end else begin
            header_done = 1'b1;
         end
      end

      if (header_done) begin
         left_in      = length_in;
         key_index_in = 2'd0;
         if (length_in == 64'd0) begin
            phase_in = wsd_pkg::PH_HDR0;
         end else begin
            phase_in = wsd_pkg::PH_PAYLOAD;
         end
      end
   end

   assign res_valid          = step.step && (header_done || payload_out);
   assign res.is_header      = header_done;
   assign res.final_fragment = fin_in;
   assign res.frame_opcode   = opcode_in;
   assign res.is_control     = opcode_in[3];
   assign res.was_masked     = mask_in;
   assign res.frame_length   = length_in;
   assign res.payload_byte   = payload_out ? (b ^ key_byte) : 8'd0;
   assign res.end_of_frame   = header_done ? (length_in == 64'd0) : last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wsd_pkg::PH_HDR0;
         fin_ff       <= 1'b0;
         opcode_ff    <= 4'd0;
         mask_ff      <= 1'b0;
         length_ff    <= 64'd0;
         count_ff     <= 3'd0;
         key_ff       <= 32'd0;
         left_ff      <= 64'd0;
         key_index_ff <= 2'd0;
      end else if (step.step) begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         mask_ff      <= mask_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         key_ff       <= key_in;
         left_ff      <= left_in;
         key_index_ff <= key_index_in;
      end
   end

   a_payload_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step.step && phase_ff == wsd_pkg::PH_PAYLOAD) |-> res_valid)
      else $error("payload item gave no result");

   a_header_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.is_header) |-> (res.payload_byte == 8'd0))
      else $error("header result carries a payload byte");

   a_key_count_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsd_pkg::PH_KEY) |-> (count_ff < wsd_pkg::KEY_BYTES))
      else $error("key byte count out of range");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.end_of_frame) |=> (phase_ff == wsd_pkg::PH_HDR0))
      else $error("frame end did not return to first header byte");

endmodule

### src/wsd_out_reg.sv
module wsd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  wsd_pkg::result_type res,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_is_header,
   output logic                rsp_final_fragment,
   output logic [3:0]          rsp_frame_opcode,
   output logic                rsp_is_control,
   output logic                rsp_was_masked,
   output logic [63:0]         rsp_frame_length,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_end_of_frame
);

   logic                valid_ff;
   logic                valid_in;
   wsd_pkg::result_type data_ff;

   assign out_free = !(valid_ff && rsp_stall);
   assign valid_in = res_valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_is_header      = data_ff.is_header;
   assign rsp_final_fragment = data_ff.final_fragment;
   assign rsp_frame_opcode   = data_ff.frame_opcode;
   assign rsp_is_control     = data_ff.is_control;
   assign rsp_was_masked     = data_ff.was_masked;
   assign rsp_frame_length   = data_ff.frame_length;
   assign rsp_payload_byte   = data_ff.payload_byte;
   assign rsp_end_of_frame   = data_ff.end_of_frame;

endmodule

### src/websocket_frame_deframer.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    rx_byte (8)
// rsp_      out        rsp_valid/stall    header summary or unmasked payload byte
//
// One byte is accepted every cycle while rsp_stall is low.
// A taken byte waits in the input register and is parsed when that register advances; its result is registered.
// Header bytes that do not complete the header give no result.
// Reset is synchronous and returns the parser to the first header byte.
// When the result register is stalled, a full input register holds and req_stall rises.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_header,
   output logic        rsp_final_fragment,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_is_control,
   output logic        rsp_was_masked,
   output logic [63:0] rsp_frame_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_end_of_frame
);

   wsd_pkg::step_type   step;
   wsd_pkg::result_type res;
   logic                res_valid;
   logic                out_free;

   wsd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_free    (out_free),
      .step        (step)
   );

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_out_reg u_out_reg (
      .clock              (clock),
      .reset              (reset),
      .res_valid          (res_valid),
      .res                (res),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_header      (rsp_is_header),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_is_control     (rsp_is_control),
      .rsp_was_masked     (rsp_was_masked),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_end_of_frame   (rsp_end_of_frame)
   );

endmodule

### tb/websocket_frame_deframer_checker.sv
`timescale 1ns / 100ps

module websocket_frame_deframer_checker
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_is_header,
   input  logic        rsp_final_fragment,
   input  logic [3:0]  rsp_frame_opcode,
   input  logic        rsp_is_control,
   input  logic        rsp_was_masked,
   input  logic [63:0] rsp_frame_length,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_end_of_frame,
   output int          mismatch_count,
   output int          results_owed
);

   result_type  owed_results[$];
   phase_type   frame_phase;
   logic        fin_seen;
   logic [3:0]  opcode_seen;
   logic        masked_seen;
   logic [63:0] decoded_length;
   logic [2:0]  field_bytes;
   logic [31:0] unmask_key;
   logic [63:0] payload_left;
   logic [1:0]  key_pos;

   task automatic give_result(input logic hdr, input logic [7:0] pbyte, input logic eof);
      result_type r;
      r.is_header      = hdr;
      r.final_fragment = fin_seen;
      r.frame_opcode   = opcode_seen;
      r.is_control     = (opcode_seen >= 4'h8);
      r.was_masked     = masked_seen;
      r.frame_length   = decoded_length;
      r.payload_byte   = pbyte;
      r.end_of_frame   = eof;
      owed_results.insert(owed_results.size(), r);
   endtask

   task automatic close_header();
      payload_left = decoded_length;
      key_pos = 2'd0;
      if (decoded_length == 64'd0) begin
         give_result(1'b1, 8'h00, 1'b1);
         frame_phase = PH_HDR0;
      end else begin
         give_result(1'b1, 8'h00, 1'b0);
         frame_phase = PH_PAYLOAD;
      end
   endtask

   task automatic length_known();
      field_bytes = 3'd0;
      if (masked_seen) begin
         frame_phase = PH_KEY;
      end else begin
         close_header();
      end
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      case (frame_phase)
         PH_HDR1: begin
            masked_seen = b[7];
            field_bytes = 3'd0;
            if (b[6:0] == LEN_CODE_EXT16) begin
               decoded_length = 64'd0;
               frame_phase = PH_EXT16;
            end else if (b[6:0] == LEN_CODE_EXT64) begin
               decoded_length = 64'd0;
               frame_phase = PH_EXT64;
            end else begin
               decoded_length = {57'd0, b[6:0]};
               length_known();
            end
         end
         PH_EXT16, PH_EXT64: begin
            decoded_length = {decoded_length[55:0], b};
            field_bytes = field_bytes + 3'd1;
            if ((frame_phase == PH_EXT16 && field_bytes == EXT16_BYTES) ||
                (frame_phase == PH_EXT64 && field_bytes == EXT64_BYTES)) begin
               length_known();
            end
         end
         PH_KEY: begin
            unmask_key = {unmask_key[23:0], b};
            field_bytes = field_bytes + 3'd1;
            if (field_bytes == KEY_BYTES) begin
               close_header();
            end
         end
         PH_PAYLOAD: begin
            key_byte = unmask_key[8 * (3 - key_pos) +: 8];
            payload_left = payload_left - 64'd1;
            key_pos = key_pos + 2'd1;
            give_result(1'b0, b ^ key_byte, payload_left == 64'd0);
            if (payload_left == 64'd0) begin
               frame_phase = PH_HDR0;
            end
         end
         default: begin
            fin_seen = b[7];
            opcode_seen = b[3:0];
            masked_seen = 1'b0;
            unmask_key = 32'd0;
            decoded_length = 64'd0;
            field_bytes = 3'd0;
            payload_left = 64'd0;
            key_pos = 2'd0;
            frame_phase = PH_HDR1;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got,
                              inout logic bad);
      if (want !== got) begin
         bad = 1'b1;
         if (mismatch_count < 10) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      logic       bad;
      if (reset) begin
         owed_results.delete();
         mismatch_count = 0;
         frame_phase = PH_HDR0;
         fin_seen = 1'b0;
         opcode_seen = 4'd0;
         masked_seen = 1'b0;
         decoded_length = 64'd0;
         field_bytes = 3'd0;
         unmask_key = 32'd0;
         payload_left = 64'd0;
         key_pos = 2'd0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: result item with none expected", $realtime);
               end
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               bad = 1'b0;
               check_field("is_header", 64'(want.is_header), 64'(rsp_is_header), bad);
               check_field("final_fragment", 64'(want.final_fragment),
                           64'(rsp_final_fragment), bad);
               check_field("frame_opcode", 64'(want.frame_opcode), 64'(rsp_frame_opcode), bad);
               check_field("is_control", 64'(want.is_control), 64'(rsp_is_control), bad);
               check_field("was_masked", 64'(want.was_masked), 64'(rsp_was_masked), bad);
               check_field("frame_length", want.frame_length, rsp_frame_length, bad);
               check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_payload_byte), bad);
               check_field("end_of_frame", 64'(want.end_of_frame), 64'(rsp_end_of_frame), bad);
               if (bad) begin
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte);
         end
      end
      results_owed <= owed_results.size();
   end

endmodule

### tb/websocket_frame_deframer_tb.sv
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
   import wsd_pkg::*;

   typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} length_form_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_is_header;
   logic        rsp_final_fragment;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_is_control;
   logic        rsp_was_masked;
   logic [63:0] rsp_frame_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_end_of_frame;
   int          mismatch_count;
   int          results_owed;
   int          sent_count;
   bit          quiet;

   websocket_frame_deframer dut (.*);

   websocket_frame_deframer_checker frame_checker (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #10_000_000;
      $display("websocket_frame_deframer_tb NOT OK");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // A negative fill gives random payload bytes.
   task automatic send_frame(input logic [7:0] first, input logic masked,
                             input length_form_type form, input logic [63:0] len,
                             input logic [31:0] key, input int fill);
      logic [63:0] i;
      send_byte(first);
      case (form)
         FORM_SHORT: begin
            send_byte({masked, len[6:0]});
         end
         FORM_EXT16: begin
            send_byte({masked, LEN_CODE_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, LEN_CODE_EXT64});
            for (int k = 7; k >= 0; k--) send_byte(len[8 * k +: 8]);
         end
      endcase
      if (masked) begin
         for (int k = 3; k >= 0; k--) send_byte(key[8 * k +: 8]);
      end
      for (i = 64'd0; i < len; i++) begin
         send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
      end
   endtask

   initial begin
      length_form_type form;
      logic [63:0]     len;
      int              pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      quiet = 1'b0;
      sent_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty frames, with and without a key, and short fixed payloads.
      send_frame(8'h81, 1'b0, FORM_SHORT, 64'd0, 32'h0, 0);
      send_frame(8'h88, 1'b1, FORM_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
      send_frame(8'h89, 1'b0, FORM_SHORT, 64'd1, 32'h0, 8'hFF);
      send_frame(8'h02, 1'b1, FORM_SHORT, 64'd2, 32'hA5C3_0FF0, 8'h00);
      send_frame(8'h7F, 1'b0, FORM_EXT64, 64'd1, 32'h0, 8'hFF);

      while (sent_count < 200) begin
         pick = $urandom_range(0, 9);
         form = pick < 7 ? FORM_SHORT : (pick < 9 ? FORM_EXT16 : FORM_EXT64);
         case (form)
            FORM_SHORT: len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                                          : 64'($urandom_range(0, 12));
            FORM_EXT16: len = 64'($urandom_range(0, 300));
            default:    len = 64'($urandom_range(0, 40));
         endcase
         send_frame(8'($urandom), 1'($urandom_range(0, 1)), form, len, $urandom, -1);
      end

      // The last part runs without idling and includes a length byte with its top bit set.
      quiet = 1'b1;
      send_frame(8'h82, 1'b1, FORM_SHORT, 64'd125, $urandom, -1);
      send_frame(8'h81, 1'b1, FORM_EXT16, 64'h00A0, $urandom, -1);
      send_frame(8'h8A, 1'b0, FORM_SHORT, 64'd3, 32'h0, -1);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("websocket_frame_deframer_tb OK");
      end else begin
         $display("websocket_frame_deframer_tb NOT OK");
      end
      $finish;
   end

endmodule
